FILE: rtl/core/erd_pkg.sv
// ----------------------------------------------------------------------------
// erd_pkg
// Shared types, codes and constants of the elevation record decoder.
// ----------------------------------------------------------------------------
package erd_pkg;

    // Fixed field widths.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COL_W    = 16;
    localparam int unsigned ELEV_W   = 16;
    localparam int unsigned ROW_W    = 12;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned CHK_W    = 2;
    localparam int unsigned POS_W    = 14;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned LIMIT_W  = 22;
    localparam int unsigned ROWS_W   = 13;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CADDR_W  = 2;
    localparam int unsigned IN_W     = 24;
    localparam int unsigned OUT_W    = 64;

    // Largest row count, default of the top-level parameter.
    localparam int unsigned MAX_ROWS_DEF = 4096;

    // Record layout.
    localparam int unsigned HEADER_LEN = 8;
    localparam int unsigned CHK_LEN    = 4;

    // Reset values of the configuration registers and the derived limits.
    localparam int unsigned RST_ROWS     = 1201;
    localparam int unsigned RST_DATA_END = HEADER_LEN + 2 * RST_ROWS;
    localparam int unsigned RST_LAST     = RST_DATA_END + CHK_LEN - 1;
    localparam int unsigned RST_LIMIT    = 255 * RST_DATA_END;
    localparam logic [ELEV_W-1:0] RST_NODATA = 16'h8001;

    // Magnitude above which a negative sample falls back to two's complement.
    localparam logic [14:0] MAG_LIMIT = 15'd16000;

    // Configuration register indexes.
    localparam logic [CADDR_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CADDR_W-1:0] REG_VERIFY    = 2'd1;
    localparam logic [CADDR_W-1:0] REG_NODATA    = 2'd2;

    // Result kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Checksum verdicts.
    localparam logic [CHK_W-1:0] CHK_OK         = 2'd0;
    localparam logic [CHK_W-1:0] CHK_MISMATCH   = 2'd1;
    localparam logic [CHK_W-1:0] CHK_IMPOSSIBLE = 2'd2;

    // Queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Decoded configuration seen by the front and back.
    typedef struct packed {
        logic [POS_W-1:0]   data_end;
        logic [POS_W-1:0]   last_pos;
        logic [LIMIT_W-1:0] limit;
        logic               verify;
        logic [ELEV_W-1:0]  nodata;
    } t_cfg;

    // One classified operation passed from front to back.
    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  hi;
        logic [BYTE_W-1:0]  lo;
        logic [ROW_W-1:0]   row;
        logic [CNT_W-1:0]   block;
        logic [CNT_W-1:0]   lon;
        logic               mismatch;
        logic [CHK_W-1:0]   status;
    } t_op;

endpackage

FILE: rtl/core/erd_front.sv
// ----------------------------------------------------------------------------
// erd_front
// Tracks the byte position in a record, collects header, sum and checksum,
// and issues one operation per completed sample or finished record.
// ----------------------------------------------------------------------------
module erd_front
    import erd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [BYTE_W-1:0]  i_byte,
    input  logic [COL_W-1:0]   i_column,
    input  logic               i_full,
    output logic               o_push,
    output t_op                o_op
);

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [SUM_W-1:0]  r_sum,   n_sum;
    logic [SUM_W-1:0]  r_chk,   n_chk;
    logic [BYTE_W-1:0] r_held,  n_held;
    logic [CNT_W-1:0]  r_block, n_block;
    logic [CNT_W-1:0]  r_lon,   n_lon;
    logic [COL_W-1:0]  r_col,   n_col;
    logic              accept;
    logic              start;
    logic [POS_W-1:0]  rel_pos;

    assign o_ready = ~i_full;
    assign accept  = i_valid & o_ready;
    assign start   = (r_pos == '0);
    assign rel_pos = r_pos - POS_W'(HEADER_LEN);

    // Next state and operation for the byte at the current position.
    always_comb begin
        n_pos   = r_pos;
        n_sum   = start ? '0 : r_sum;
        n_chk   = start ? '0 : r_chk;
        n_held  = r_held;
        n_block = r_block;
        n_lon   = r_lon;
        n_col   = start ? i_column : r_col;
        o_push  = 1'b0;
        o_op    = '0;

        if (r_pos < i_cfg.data_end) begin
            n_sum = n_sum + SUM_W'(i_byte);
            case (r_pos)
                POS_W'(2): n_block = {i_byte, r_block[7:0]};
                POS_W'(3): n_block = {r_block[15:8], i_byte};
                POS_W'(4): n_lon   = {i_byte, r_lon[7:0]};
                POS_W'(5): n_lon   = {r_lon[15:8], i_byte};
                default: begin
                    if (r_pos >= POS_W'(HEADER_LEN)) begin
                        if (!r_pos[0]) begin
                            n_held = i_byte;
                        end else begin
                            o_push  = accept;
                            o_op.kind = KIND_SAMPLE;
                            o_op.hi   = r_held;
                            o_op.lo   = i_byte;
                            o_op.row  = rel_pos[ROW_W:1];
                        end
                    end
                end
            endcase
        end else begin
            n_chk = {n_chk[SUM_W-BYTE_W-1:0], i_byte};
        end

        // The final byte closes the record with a status word.
        if (r_pos >= i_cfg.last_pos) begin
            n_pos          = '0;
            o_push         = accept;
            o_op.kind      = KIND_STATUS;
            o_op.block     = r_block;
            o_op.lon       = r_lon;
            o_op.mismatch  = (r_lon != n_col);
            o_op.status    = CHK_OK;
            if (i_cfg.verify) begin
                if (n_chk > {{(SUM_W-LIMIT_W){1'b0}}, i_cfg.limit}) begin
                    o_op.status = CHK_IMPOSSIBLE;
                end else if (n_chk != n_sum) begin
                    o_op.status = CHK_MISMATCH;
                end
            end
        end else begin
            n_pos = r_pos + 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

    // Record state, reset to zero as the record format expects.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_chk   <= '0;
            r_held  <= '0;
            r_block <= '0;
            r_lon   <= '0;
            r_col   <= '0;
        end else if (accept) begin
            r_sum   <= n_sum;
            r_chk   <= n_chk;
            r_held  <= n_held;
            r_block <= n_block;
            r_lon   <= n_lon;
            r_col   <= n_col;
        end
    end

endmodule

FILE: rtl/core/erd_queue.sv
// ----------------------------------------------------------------------------
// erd_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module erd_queue
    import erd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];
    assign do_pop  = i_pop & o_valid;

    // Pointer and fill count updates.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

FILE: rtl/core/erd_back.sv
// ----------------------------------------------------------------------------
// erd_back
// Decodes signed-magnitude samples and formats result words into the
// output register.
// ----------------------------------------------------------------------------
module erd_back
    import erd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ELEV_W-1:0] i_nodata,
    input  logic              i_valid,
    input  t_op               i_op,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [OUT_W-1:0]  o_tdata,
    output logic              o_tuser,
    output logic              o_tlast
);

    logic              r_valid;
    logic [OUT_W-1:0]  r_data, n_data;
    logic              r_kind;
    logic              r_last;
    logic [14:0]       mag;
    logic [ELEV_W-1:0] neg;
    logic [ELEV_W-1:0] elev;

    assign o_pop    = i_valid & (~r_valid | i_tready);
    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_kind;
    assign o_tlast  = r_last;

    // Signed-magnitude sample with the two's complement fallback.
    assign mag = {i_op.hi[6:0], i_op.lo};
    assign neg = ELEV_W'(0) - {1'b0, mag};
    always_comb begin
        if (!i_op.hi[7]) begin
            elev = {1'b0, mag};
        end else if (mag > MAG_LIMIT && neg != i_nodata) begin
            elev = {i_op.hi, i_op.lo};
        end else begin
            elev = neg;
        end
    end

    // Result word: fields from the low bit up.
    always_comb begin
        n_data = '0;
        if (i_op.kind == KIND_SAMPLE) begin
            n_data[15:0]  = elev;
            n_data[27:16] = i_op.row;
        end else begin
            n_data[43:28] = i_op.block;
            n_data[59:44] = i_op.lon;
            n_data[60]    = i_op.mismatch;
            n_data[62:61] = i_op.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
            r_kind <= i_op.kind;
            r_last <= (i_op.kind == KIND_STATUS);
        end
    end

endmodule

FILE: rtl/core/elevation_record_decoder.sv
// A result word enters the queue as its final byte is accepted, then moves
// into the output register. Throughput: one record byte per cycle while the
// queue is not full; the output register and a two-entry queue let the input
// keep flowing while a result waits to be taken.
// Reset clears the byte position, the record sums and the queue, and sets
// the registers to 1201 rows, verification off and nodata -32767.
// ----------------------------------------------------------------------------
// elevation_record_decoder
// Decodes terrain column records arriving one byte per word into elevation
// samples and an end-of-record status word.
// ----------------------------------------------------------------------------
module elevation_record_decoder
    import erd_pkg::*;
#(
    parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // Input stream: [7:0] record_byte, [23:8] expected_column.
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [IN_W-1:0]    i_s_tdata,
    // Output stream: [15:0] elevation, [27:16] row_index, [43:28] block_count,
    // [59:44] longitude_count, [60] column_mismatch, [62:61] check_status,
    // [63] zero.
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [OUT_W-1:0]   o_m_tdata,
    // Output user: [0] result_kind.
    output logic               o_m_tuser,
    output logic               o_m_tlast
);

    // Reset limits, with the reset row count held to the largest row count.
    localparam int unsigned RST_ROWS_USE  = (RST_ROWS > MAX_ROWS) ? MAX_ROWS : RST_ROWS;
    localparam int unsigned RST_END_USE   = HEADER_LEN + 2 * RST_ROWS_USE;
    localparam int unsigned RST_LAST_USE  = RST_END_USE + CHK_LEN - 1;
    localparam int unsigned RST_LIMIT_USE = 255 * RST_END_USE;

    t_cfg               r_cfg, n_cfg;
    logic [ROWS_W-1:0]  rows;
    logic [POS_W-1:0]   data_end;
    logic               full;
    logic               push;
    t_op                push_op;
    logic               pop;
    logic               head_valid;
    t_op                head_op;

    assign o_cfg_ready = 1'b1;

    // Row count clamped to its legal range, then the derived record limits.
    always_comb begin
        rows = i_cfg_data[ROWS_W-1:0];
        if (rows == '0) begin
            rows = ROWS_W'(1);
        end else if (rows > ROWS_W'(MAX_ROWS)) begin
            rows = ROWS_W'(MAX_ROWS);
        end
        data_end = POS_W'(HEADER_LEN) + {rows, 1'b0};
    end

    // Configuration register writes.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_ROW_COUNT: begin
                    n_cfg.data_end = data_end;
                    n_cfg.last_pos = data_end + POS_W'(CHK_LEN - 1);
                    n_cfg.limit    = {data_end, 8'd0} - LIMIT_W'(data_end);
                end
                REG_VERIFY: n_cfg.verify = i_cfg_data[0];
                REG_NODATA: n_cfg.nodata = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_end <= POS_W'(RST_END_USE);
            r_cfg.last_pos <= POS_W'(RST_LAST_USE);
            r_cfg.limit    <= LIMIT_W'(RST_LIMIT_USE);
            r_cfg.verify   <= 1'b0;
            r_cfg.nodata   <= RST_NODATA;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    erd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_byte   (i_s_tdata[7:0]),
        .i_column (i_s_tdata[23:8]),
        .i_full   (full),
        .o_push   (push),
        .o_op     (push_op)
    );

    erd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_op    (head_op)
    );

    erd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_nodata (r_cfg.nodata),
        .i_valid  (head_valid),
        .i_op     (head_op),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

endmodule

FILE: tb/tb_elevation_record_decoder.sv
// ----------------------------------------------------------------------------
// tb_elevation_record_decoder
// Self-checking bench for the terrain column record decoder. Record bytes go
// in on the input stream, and an in-bench decoder model predicts every
// elevation sample and end-of-record status word. A short table of
// hand-checked bytes comes first. Phases of random, mostly well-formed
// records follow, with shifting register settings, idle and stall patterns
// and a long output hold-off. A row count above the top of the range is
// also written and its record closed by a later, smaller row count.
// ----------------------------------------------------------------------------
module tb_elevation_record_decoder;
    import erd_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned PHASE_BYTES    = 85;
    localparam int unsigned SETTLE_WAIT    = 4;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned PLAN_LEN       = 28;
    localparam int unsigned BIG_OPEN_BYTES = 32;

    // One decoded word as the bench compares it.
    typedef struct packed {
        logic               kind;
        logic [ELEV_W-1:0]  elev;
        logic [ROW_W-1:0]   row;
        logic [CNT_W-1:0]   blk;
        logic [CNT_W-1:0]   lon;
        logic               mismatch;
        logic [CHK_W-1:0]   status;
        logic               last;
    } t_decoded_word;

    // One row of the hand-written byte table.
    typedef struct packed {
        logic [BYTE_W-1:0]  rec_byte;
        logic [COL_W-1:0]   col;
        logic               typed;
        t_decoded_word      want;
    } t_byte_plan;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_W-1:0]   i_cfg_data  = '0;
    logic               i_s_tvalid  = 1'b0;
    logic               o_s_tready;
    logic [IN_W-1:0]    i_s_tdata   = '0;
    logic               o_m_tvalid;
    logic               i_m_tready  = 1'b0;
    logic [OUT_W-1:0]   o_m_tdata;
    logic               o_m_tuser;
    logic               o_m_tlast;

    // Register copies and record state of the decoder model.
    logic [ROWS_W-1:0]      rows_reg   = 13'd1201;
    logic                   verify_reg = 1'b0;
    logic signed [ELEV_W-1:0] nodata_reg = RST_NODATA;
    logic [POS_W-1:0]       rec_pos    = '0;
    logic [SUM_W-1:0]       byte_sum   = '0;
    logic [BYTE_W-1:0]      high_byte  = '0;
    logic [SUM_W-1:0]       chk_word   = '0;
    logic [CNT_W-1:0]       hdr_blk    = '0;
    logic [CNT_W-1:0]       hdr_lon    = '0;
    logic [COL_W-1:0]       col_latch  = '0;

    t_decoded_word  decoded_q[$];
    t_byte_plan     plan [PLAN_LEN];
    int unsigned    send_idle_pct = 0;
    int unsigned    stall_pct     = 0;
    int unsigned    hold_left     = 0;
    int unsigned    cycles        = 0;
    int unsigned    fails         = 0;
    int unsigned    bytes_sent    = 0;
    int unsigned    samples_seen  = 0;
    int unsigned    status_seen   = 0;

    elevation_record_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Run-time guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_decoded_word sample_word(input logic [ELEV_W-1:0] elev,
                                                  input logic [ROW_W-1:0] row);
        t_decoded_word w;
        w = '0;
        w.kind = KIND_SAMPLE;
        w.elev = elev;
        w.row  = row;
        return w;
    endfunction

    function automatic t_decoded_word status_word(input logic [CNT_W-1:0] blk,
                                                  input logic [CNT_W-1:0] lon,
                                                  input logic mismatch,
                                                  input logic [CHK_W-1:0] status);
        t_decoded_word w;
        w = '0;
        w.kind     = KIND_STATUS;
        w.blk      = blk;
        w.lon      = lon;
        w.mismatch = mismatch;
        w.status   = status;
        w.last     = 1'b1;
        return w;
    endfunction

    // Row count in force: the register clamped to 1..4096.
    function automatic int unsigned rows_in_use();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > MAX_ROWS_DEF)
            return MAX_ROWS_DEF;
        return rows_reg;
    endfunction

    // Signed-magnitude decode with the two's complement fallback for large
    // negatives that are not the nodata value.
    function automatic logic [ELEV_W-1:0] elevation_of(input logic [BYTE_W-1:0] hi,
                                                       input logic [BYTE_W-1:0] lo);
        int v;
        int nd;
        v  = int'({hi[6:0], lo});
        nd = nodata_reg;
        if (hi[7]) begin
            v = -v;
            if (v < -16000 && v != nd)
                return {hi, lo};
        end
        return v[ELEV_W-1:0];
    endfunction

    // Advances the record model by one byte; returns 1 when a word results.
    function automatic logic advance_decoder(input logic [BYTE_W-1:0] b,
                                             input logic [COL_W-1:0] col,
                                             output t_decoded_word w);
        int unsigned       data_end;
        int unsigned       last_pos;
        logic [POS_W-1:0]  offs;
        logic [SUM_W-1:0]  lim;
        logic [CHK_W-1:0]  st;
        logic              has;
        data_end = 8 + 2 * rows_in_use();
        last_pos = data_end + 3;
        offs     = rec_pos - 14'd8;
        w        = '0;
        has      = 1'b0;
        if (rec_pos == 0) begin
            col_latch = col;
            byte_sum  = '0;
            chk_word  = '0;
        end
        if (rec_pos < data_end) begin
            byte_sum = byte_sum + b;
            if (rec_pos == 2)
                hdr_blk[15:8] = b;
            else if (rec_pos == 3)
                hdr_blk[7:0] = b;
            else if (rec_pos == 4)
                hdr_lon[15:8] = b;
            else if (rec_pos == 5)
                hdr_lon[7:0] = b;
            else if (rec_pos >= 8) begin
                if (!offs[0]) begin
                    high_byte = b;
                end else begin
                    w   = sample_word(elevation_of(high_byte, b), offs[12:1]);
                    has = 1'b1;
                end
            end
        end else begin
            chk_word = {chk_word[23:0], b};
        end
        if (rec_pos >= last_pos) begin
            st = CHK_OK;
            if (verify_reg) begin
                lim = 32'd255 * data_end;
                if (chk_word > lim)
                    st = CHK_IMPOSSIBLE;
                else if (chk_word != byte_sum)
                    st = CHK_MISMATCH;
            end
            w       = status_word(hdr_blk, hdr_lon, hdr_lon != col_latch, st);
            has     = 1'b1;
            rec_pos = '0;
        end else begin
            rec_pos = rec_pos + 1'b1;
        end
        return has;
    endfunction

    function automatic t_byte_plan step(input logic [BYTE_W-1:0] b,
                                        input logic [COL_W-1:0] col);
        return {b, col, 1'b0, t_decoded_word'('0)};
    endfunction

    function automatic t_byte_plan step_res(input logic [BYTE_W-1:0] b,
                                            input logic [COL_W-1:0] col,
                                            input t_decoded_word want);
        return {b, col, 1'b1, want};
    endfunction

    task automatic check_field(input string name, input logic [ELEV_W-1:0] want,
                               input logic [ELEV_W-1:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            fails++;
        end
    endtask

    // Compares an accepted output word with the oldest prediction.
    task automatic check_word();
        t_decoded_word want;
        if (decoded_q.size() == 0) begin
            $error("output word 0x%0h arrived with nothing expected", o_m_tdata);
            fails++;
            return;
        end
        want = decoded_q.pop_front();
        if (want.kind == KIND_STATUS)
            status_seen++;
        else
            samples_seen++;
        check_field("result_kind", 16'(want.kind), 16'(o_m_tuser));
        check_field("elevation", want.elev, o_m_tdata[15:0]);
        check_field("row_index", 16'(want.row), 16'(o_m_tdata[27:16]));
        check_field("block_count", want.blk, o_m_tdata[43:28]);
        check_field("longitude_count", want.lon, o_m_tdata[59:44]);
        check_field("column_mismatch", 16'(want.mismatch), 16'(o_m_tdata[60]));
        check_field("check_status", 16'(want.status), 16'(o_m_tdata[62:61]));
        check_field("record_last", 16'(want.last), 16'(o_m_tlast));
    endtask

    // Output side: check each accepted word, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            check_word();
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one byte, waits for it to be taken and records the prediction.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic [COL_W-1:0] col,
                             input logic typed, input t_decoded_word want);
        t_decoded_word got;
        logic          has;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {col, b};
        do @(posedge i_clk); while (!o_s_tready);
        has = advance_decoder(b, col, got);
        if (typed)
            decoded_q.push_back(want);
        else if (has)
            decoded_q.push_back(got);
        bytes_sent++;
    endtask

    task automatic push_random();
        push_byte(8'($urandom), 16'($urandom), 1'b0, '0);
    endtask

    // Stops sending and waits until every predicted word has come out.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_ROW_COUNT: rows_reg   = val[ROWS_W-1:0];
            REG_VERIFY:    verify_reg = val[0];
            REG_NODATA:    nodata_reg = val;
            default: ;
        endcase
    endtask

    // Picks a sample word, leaning on the fallback range and nodata.
    function automatic logic [15:0] pick_sample();
        int          nd;
        logic [15:0] s;
        nd = nodata_reg;
        case ($urandom_range(5))
            0: s = 16'($urandom);
            1: s = {1'b1, 15'($urandom_range(16001, 32767))};
            2: s = {1'b1, 15'($urandom_range(15990, 16010))};
            3: begin
                if (nd < -16000 && nd > -32768)
                    s = {1'b1, 15'(-nd)};
                else
                    s = 16'($urandom);
            end
            4: begin
                case ($urandom_range(3))
                    0: s = 16'h0000;
                    1: s = 16'h8000;
                    2: s = 16'h7fff;
                    default: s = 16'hffff;
                endcase
            end
            default: s = {1'b0, 15'($urandom)};
        endcase
        return s;
    endfunction

    // Sends one record at the row count in force. A record left open by an
    // earlier phase is finished first with random bytes.
    task automatic send_record(input logic allow_noise);
        int unsigned      rows;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] chk;
        logic [SUM_W-1:0] lim;
        logic [15:0]      smp;
        logic [7:0]       hdr [8];
        logic [COL_W-1:0] col;
        while (rec_pos != 0)
            push_random();
        rows = rows_in_use();
        if (allow_noise && $urandom_range(99) < 15) begin
            repeat (12 + 2 * rows) push_random();
            return;
        end
        foreach (hdr[i])
            hdr[i] = 8'($urandom);
        if ($urandom_range(1))
            hdr[0] = 8'haa;
        col = $urandom_range(99) < 60 ? {hdr[4], hdr[5]} : 16'($urandom);
        sum = '0;
        foreach (hdr[i]) begin
            sum = sum + hdr[i];
            push_byte(hdr[i], i == 0 ? col : 16'($urandom), 1'b0, '0);
        end
        for (int r = 0; r < rows; r++) begin
            smp = pick_sample();
            sum = sum + smp[15:8] + smp[7:0];
            push_byte(smp[15:8], 16'($urandom), 1'b0, '0);
            push_byte(smp[7:0], 16'($urandom), 1'b0, '0);
        end
        lim = 32'd255 * (8 + 2 * rows);
        case ($urandom_range(4))
            0, 1: chk = sum;
            2:    chk = sum + $urandom_range(1, 400);
            3:    chk = $urandom_range(1) ? lim : lim + 1;
            default: chk = $urandom;
        endcase
        for (int k = 3; k >= 0; k--)
            push_byte(chk[8*k +: 8], 16'($urandom), 1'b0, '0);
    endtask

    // Stimulus and run control.
    initial begin
        int unsigned phase_start;
        int unsigned rows_pick [8];
        int unsigned idle_pick [4];
        int unsigned stall_pick [4];
        logic [15:0] nodata_pick;
        rows_pick  = '{2, 0, 3, 5, 1, 7, 4, 6};
        idle_pick  = '{0, 62, 0, 30};
        stall_pick = '{0, 0, 62, 30};

        // Record A: the usual sentinel, block count all ones, longitude zero
        // against column 0xffff, the nodata sample (kept as -32767), and a
        // checksum far above what the record could sum to.
        // Record B: a zero sentinel, the largest positive sample, a matching
        // column, and a checksum one above the true byte sum.
        plan = '{
            step(8'haa, 16'hffff), step(8'h00, 16'h0000),
            step(8'hff, 16'h0000), step(8'hff, 16'h0000),
            step(8'h00, 16'h0000), step(8'h00, 16'h0000),
            step(8'h00, 16'h0000), step(8'h00, 16'h0000),
            step(8'hff, 16'h0000),
            step_res(8'hff, 16'h0000, sample_word(16'h8001, 12'd0)),
            step(8'h12, 16'h0000), step(8'h34, 16'h0000), step(8'h56, 16'h0000),
            step_res(8'h78, 16'h0000,
                     status_word(16'hffff, 16'h0000, 1'b1, CHK_IMPOSSIBLE)),
            step(8'h00, 16'h1234), step(8'h00, 16'hffff),
            step(8'h00, 16'hffff), step(8'h00, 16'hffff),
            step(8'h12, 16'hffff), step(8'h34, 16'hffff),
            step(8'h00, 16'hffff), step(8'h00, 16'hffff),
            step(8'h7f, 16'hffff),
            step_res(8'hff, 16'hffff, sample_word(16'h7fff, 12'd0)),
            step(8'h00, 16'hffff), step(8'h00, 16'hffff), step(8'h01, 16'hffff),
            step_res(8'hc5, 16'hffff,
                     status_word(16'h0000, 16'h1234, 1'b0, CHK_MISMATCH))
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Hand-checked table at one row per record, checksum verification on.
        write_reg(REG_ROW_COUNT, 16'd1);
        write_reg(REG_VERIFY, 16'd1);
        foreach (plan[i])
            push_byte(plan[i].rec_byte, plan[i].col, plan[i].typed, plan[i].want);

        // A row count written above the clamp; the record stays open and the
        // row count of the first random phase closes it.
        write_reg(REG_ROW_COUNT, 16'd8191);
        repeat (BIG_OPEN_BYTES) push_random();

        // Random phases: each sets all registers, then sends records.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: nodata_pick = 16'h8000;
                1: nodata_pick = 16'h7fff;
                2: nodata_pick = 16'hb1e0;
                default: nodata_pick = 16'h8000 + 16'($urandom_range(0, 16'h417f));
            endcase
            write_reg(REG_ROW_COUNT, 16'(rows_pick[ph]));
            write_reg(REG_VERIFY, 16'(ph % 3 != 1));
            write_reg(REG_NODATA, nodata_pick);
            send_idle_pct = idle_pick[ph % 4];
            stall_pct     = stall_pick[ph % 4];
            // Long output hold-off while bytes keep coming, so the input backs up.
            if (ph == 0)
                hold_left = HOLD_CYCLES;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_record(1'b1);
            // Leave a record open so the next row count lands mid-record.
            if (ph % 2 == 0 || $urandom_range(1))
                repeat ($urandom_range(1, 2 * rows_in_use() + 11)) push_random();
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        settle();
        repeat (8) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            $error("%0d expected words never arrived", decoded_q.size());
            fails++;
        end
        $display("Sent %0d record bytes; checked %0d samples and %0d status words.",
                 bytes_sent, samples_seen, status_seen);
        $display("Covered clamped and mid-record row counts, all checksum verdicts, "
                 , "nodata extremes and idle, stall and hold-off patterns.");
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
